// ----- rtl/mvna_pkg.sv -----
// Shared types and constants for the vertex normal accumulator.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package mvna_pkg;

  localparam int IDX_W    = 10;  // vertex index field width
  localparam int POS_IN_W = 16;  // coordinate field width on the port
  localparam int OUT_W    = 16;  // normal component width on the port
  localparam int MAG_W    = 30;  // normalized magnitudes lie in [2^29, 2^30)
  localparam int EDGE_W   = 34;  // difference of two coordinates, sign included
  localparam int VEC_W    = 62;  // cross product or sum, sign included
  localparam int ROOT_W   = 31;  // square root of the sum of squares
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TRI   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_WRITE,
    K_TRI,
    K_READ,
    K_READ_BAD,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [IDX_W-1:0]    vidx;
    logic [IDX_W-1:0]    a;
    logic [IDX_W-1:0]    b;
    logic [IDX_W-1:0]    c;
    logic [POS_IN_W-1:0] x;
    logic [POS_IN_W-1:0] y;
    logic [POS_IN_W-1:0] z;
  } cmd_t;

  typedef enum logic [3:0] {
    B_CLR,
    B_IDLE,
    B_T_RA,
    B_T_RB,
    B_T_RC,
    B_T_RD,
    B_CROSS,
    B_U_GO,
    B_U_WAIT,
    B_ACC_RD,
    B_ACC_WR,
    B_R_RD,
    B_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_CHK,
    U_NORM,
    U_SQ,
    U_SQRT,
    U_DPREP,
    U_DIV,
    U_FIN
  } unit_state_t;

endpackage

`default_nettype wire

// ----- rtl/mvna_front.sv -----
// Input side: unpacks a request, checks its indices and classifies it.
// Depends on mvna_pkg.
`default_nettype none

module mvna_front
  import mvna_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic [1:0]           s_axis_tuser,
  input  wire logic                 q_full,
  input  wire logic                 init_done,
  output logic                      push,
  output cmd_t                      cmd
);

  op_t  op;
  logic vi_ok, a_ok, b_ok, c_ok, keep;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    idx_ok = 32'(idx) < 32'(MAX_VERTICES);
  endfunction

  assign op = op_t'(s_axis_tuser);

  always_comb begin
    cmd.vidx = s_axis_tdata[9:0];
    cmd.x    = s_axis_tdata[25:10];
    cmd.y    = s_axis_tdata[41:26];
    cmd.z    = s_axis_tdata[57:42];
    cmd.a    = s_axis_tdata[67:58];
    cmd.b    = s_axis_tdata[77:68];
    cmd.c    = s_axis_tdata[87:78];
    vi_ok = idx_ok(cmd.vidx);
    a_ok  = idx_ok(cmd.a);
    b_ok  = idx_ok(cmd.b);
    c_ok  = idx_ok(cmd.c);
    case (op)
      OP_WRITE: begin
        cmd.kind = K_WRITE;
        keep     = vi_ok;
      end
      OP_TRI: begin
        cmd.kind = K_TRI;
        keep     = a_ok & b_ok & c_ok;
      end
      OP_READ: begin
        cmd.kind = vi_ok ? K_READ : K_READ_BAD;
        keep     = 1'b1;
      end
      default: begin
        cmd.kind = K_CLEAR;
        keep     = 1'b1;
      end
    endcase
  end

  // requests with a bad index that return nothing are accepted and dropped
  assign s_axis_tready = init_done & ~q_full;
  assign push          = s_axis_tvalid & s_axis_tready & keep;

endmodule

`default_nettype wire

// ----- rtl/mvna_queue.sv -----
// Two-entry request queue between the front and the back end.
// Depends on mvna_pkg.
`default_nettype none

module mvna_queue
  import mvna_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t din,
  output logic      full,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      empty
);

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign dout  = mem[rp];

endmodule

`default_nettype wire

// ----- rtl/mvna_unit.sv -----
// Unit vector unit: normalizing shift, sum of squares, bit-serial square
// root and three restoring dividers. Depends on mvna_pkg.
`default_nettype none

module mvna_unit
  import mvna_pkg::*;
#(
  parameter int NORMAL_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [2:0][VEC_W-1:0]        vec,
  output logic                              done,
  output logic                              zero,
  output logic [2:0][NORMAL_BITS-1:0]       nrm
);

  localparam int F    = NORMAL_BITS - 1;
  localparam int QW   = F + 2;
  localparam int NUMW = F + MAG_W + 1;
  localparam int CW   = $clog2(QW + 1);
  localparam logic [QW-1:0] LIM = QW'((64'd1 << F) - 64'd1);

  unit_state_t state, state_next;

  logic [2:0][VEC_W-1:0]  m;
  logic [2:0]             neg;
  logic [VEC_W-1:0]       mx, x, res, bitv, trial;
  logic                   ge;
  logic [1:0]             sq_cnt;
  logic [MAG_W-1:0]       sq_sel;
  logic [2*MAG_W-1:0]     prod;
  logic [CW-1:0]          cnt;
  logic [ROOT_W-1:0]      r;
  logic [2:0][ROOT_W-1:0] rem;
  logic [2:0][QW-1:0]     lo;
  logic [2:0][NUMW-1:0]   num;
  logic [2:0][ROOT_W:0]   t;
  logic [2:0][QW-1:0]     qc;
  logic                   norm_ok;

  always_comb begin
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    norm_ok = (mx[VEC_W-1:MAG_W] == '0) && mx[MAG_W-1];
    trial = res + bitv;
    ge    = x >= trial;
    r     = res[ROOT_W-1:0];
    case (sq_cnt)
      2'd0:    sq_sel = m[0][MAG_W-1:0];
      2'd1:    sq_sel = m[1][MAG_W-1:0];
      default: sq_sel = m[2][MAG_W-1:0];
    endcase
    for (int i = 0; i < 3; i++) begin
      num[i] = (NUMW'(m[i][MAG_W-1:0]) << F) + NUMW'(r >> 1);
      t[i]   = {rem[i], lo[i][QW-1]};
      qc[i]  = (lo[i] > LIM) ? LIM : lo[i];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      U_IDLE:  if (start) state_next = U_CHK;
      U_CHK:   state_next = (mx == '0) ? U_IDLE : U_NORM;
      U_NORM:  if (norm_ok) state_next = U_SQ;
      U_SQ:    if (sq_cnt == 2'd3) state_next = U_SQRT;
      U_SQRT:  if (bitv[0]) state_next = U_DPREP;
      U_DPREP: state_next = U_DIV;
      U_DIV:   if (cnt == CW'(QW - 1)) state_next = U_FIN;
      U_FIN:   state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == U_CHK) && (mx == '0)) || (state == U_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vec[i][VEC_W-1];
            m[i]   <= vec[i][VEC_W-1] ? -vec[i] : vec[i];
          end
        end
      end
      U_CHK: begin
        x      <= '0;
        res    <= '0;
        bitv   <= VEC_W'(1) << (VEC_W - 2);
        sq_cnt <= 2'd0;
        if (mx == '0) begin
          zero <= 1'b1;
          nrm  <= '0;
        end
      end
      U_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (mx[VEC_W-1:MAG_W+4] != '0) m[i] <= m[i] >> 4;
          else if (mx[VEC_W-1:MAG_W] != '0) m[i] <= m[i] >> 1;
          else if (mx[VEC_W-1:MAG_W-5] == '0) m[i] <= m[i] << 4;
          else if (!mx[MAG_W-1]) m[i] <= m[i] << 1;
        end
      end
      U_SQ: begin
        prod   <= sq_sel * sq_sel;
        sq_cnt <= sq_cnt + 2'd1;
        if (sq_cnt != 2'd0) x <= x + VEC_W'(prod);
      end
      U_SQRT: begin
        if (ge) begin
          x   <= x - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      U_DPREP: begin
        cnt <= '0;
        for (int i = 0; i < 3; i++) begin
          rem[i] <= ROOT_W'(num[i] >> QW);
          lo[i]  <= num[i][QW-1:0];
        end
      end
      U_DIV: begin
        cnt <= cnt + CW'(1);
        for (int i = 0; i < 3; i++) begin
          if (t[i] >= {1'b0, r}) begin
            rem[i] <= ROOT_W'(t[i] - {1'b0, r});
            lo[i]  <= {lo[i][QW-2:0], 1'b1};
          end else begin
            rem[i] <= t[i][ROOT_W-1:0];
            lo[i]  <= {lo[i][QW-2:0], 1'b0};
          end
        end
      end
      U_FIN: begin
        zero <= 1'b0;
        for (int i = 0; i < 3; i++)
          nrm[i] <= neg[i] ? NORMAL_BITS'(-qc[i]) : NORMAL_BITS'(qc[i]);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mvna_back.sv -----
// Back end: sequencer over the position and sum memories, edge and cross
// product datapath, saturating accumulate and output register.
// Depends on mvna_pkg and mvna_unit.
`default_nettype none

module mvna_back
  import mvna_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16,
  parameter int NORMAL_BITS  = 16,
  parameter int SUM_BITS     = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_empty,
  input  wire cmd_t                  q_head,
  output logic                       q_pop,
  output logic                       init_done,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [0:0]                 m_axis_tuser
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int SW = ((SUM_BITS > NORMAL_BITS) ? SUM_BITS : NORMAL_BITS) + 1;
  localparam logic signed [SW-1:0] S_HI = SW'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] S_LO = -S_HI - SW'(1);
  localparam int EV_W = MAG_W + 1;

  back_state_t state, state_next;

  logic [3*COORD_BITS-1:0] vmem [MAX_VERTICES];
  logic [3*SUM_BITS-1:0]   smem [MAX_VERTICES];
  logic [3*COORD_BITS-1:0] vq;
  logic [3*SUM_BITS-1:0]   sq;

  cmd_t cmd;
  logic [AW-1:0] clr_cnt, v_raddr, s_raddr, s_waddr, corner_addr;
  logic [1:0]    corner;
  logic [2:0]    k;
  logic          v_wr, v_rd, s_rd, s_wr, u_start, out_load, out_free;
  logic [3*SUM_BITS-1:0] s_wdata;

  logic signed [COORD_BITS-1:0] pa [3];
  logic signed [COORD_BITS-1:0] pb [3];
  logic signed [COORD_BITS-1:0] pc [3];
  logic signed [EV_W-1:0]       ab [3];
  logic signed [EV_W-1:0]       ac [3];
  logic signed [EV_W-1:0]       ed [6];
  logic signed [EV_W-1:0]       opa, opb;
  logic signed [VEC_W-1:0]      prod;
  logic signed [VEC_W-1:0]      cr [3];
  logic [1:0]                   p_dst;
  logic                         p_sub;
  logic signed [SUM_BITS-1:0]   sf [3];
  logic signed [SW-1:0]         ts [3];
  logic [2:0][VEC_W-1:0]        u_vec;
  logic                         u_done, u_zero;
  logic [2:0][NORMAL_BITS-1:0]  u_nrm;

  // edges and their shrink to below 2^30
  always_comb begin
    logic signed [EDGE_W-1:0] e [6];
    logic [EDGE_W-1:0]        em [6];
    logic [EDGE_W-1:0]        mxe;
    logic [1:0]               sh;
    logic [EDGE_W-1:0]        sm;
    for (int i = 0; i < 3; i++) begin
      pc[i]    = signed'(vq[i*COORD_BITS +: COORD_BITS]);
      e[i]     = EDGE_W'(pb[i]) - EDGE_W'(pa[i]);
      e[i + 3] = EDGE_W'(pc[i]) - EDGE_W'(pa[i]);
    end
    for (int i = 0; i < 6; i++) em[i] = e[i][EDGE_W-1] ? -e[i] : e[i];
    for (int g = 0; g < 2; g++) begin
      mxe = em[3*g];
      if (em[3*g+1] > mxe) mxe = em[3*g+1];
      if (em[3*g+2] > mxe) mxe = em[3*g+2];
      if (mxe[EDGE_W-1:MAG_W] == '0) sh = 2'd0;
      else if (mxe[EDGE_W-1:MAG_W+1] == '0) sh = 2'd1;
      else if (mxe[EDGE_W-1:MAG_W+2] == '0) sh = 2'd2;
      else sh = 2'd3;
      for (int i = 0; i < 3; i++) begin
        sm = em[3*g+i] >> sh;
        ed[3*g+i] = e[3*g+i][EDGE_W-1] ? -signed'(EV_W'(sm)) : signed'(EV_W'(sm));
      end
    end
  end

  always_comb begin
    case (k)
      3'd0:    begin opa = ab[1]; opb = ac[2]; end
      3'd1:    begin opa = ab[2]; opb = ac[1]; end
      3'd2:    begin opa = ab[2]; opb = ac[0]; end
      3'd3:    begin opa = ab[0]; opb = ac[2]; end
      3'd4:    begin opa = ab[0]; opb = ac[1]; end
      3'd5:    begin opa = ab[1]; opb = ac[0]; end
      default: begin opa = '0;    opb = '0;    end
    endcase
  end

  always_comb begin
    case (corner)
      2'd0:    corner_addr = AW'(cmd.a);
      2'd1:    corner_addr = AW'(cmd.b);
      default: corner_addr = AW'(cmd.c);
    endcase
    for (int i = 0; i < 3; i++) begin
      sf[i] = signed'(sq[i*SUM_BITS +: SUM_BITS]);
      ts[i] = SW'(sf[i]) + SW'(signed'(u_nrm[i]));
      if (ts[i] > S_HI) ts[i] = S_HI;
      if (ts[i] < S_LO) ts[i] = S_LO;
      u_vec[i] = (cmd.kind == K_TRI) ? cr[i] : VEC_W'(sf[i]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_CLR:    if (clr_cnt == AW'(MAX_VERTICES - 1)) state_next = B_IDLE;
      B_IDLE: begin
        if (!q_empty) begin
          case (q_head.kind)
            K_TRI:      state_next = B_T_RA;
            K_READ:     state_next = B_R_RD;
            K_READ_BAD: state_next = B_OUT;
            K_CLEAR:    state_next = B_CLR;
            default:    state_next = B_IDLE;
          endcase
        end
      end
      B_T_RA:   state_next = B_T_RB;
      B_T_RB:   state_next = B_T_RC;
      B_T_RC:   state_next = B_T_RD;
      B_T_RD:   state_next = B_CROSS;
      B_CROSS:  if (k == 3'd6) state_next = B_U_GO;
      B_U_GO:   state_next = B_U_WAIT;
      B_U_WAIT: begin
        if (u_done) begin
          if (cmd.kind != K_TRI) state_next = B_OUT;
          else if (u_zero) state_next = B_IDLE;
          else state_next = B_ACC_RD;
        end
      end
      B_ACC_RD: state_next = B_ACC_WR;
      B_ACC_WR: state_next = (corner == 2'd2) ? B_IDLE : B_ACC_RD;
      B_R_RD:   state_next = B_U_GO;
      B_OUT:    if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    out_free = ~m_axis_tvalid | m_axis_tready;
    q_pop    = (state == B_IDLE) && !q_empty;
    v_wr     = q_pop && (q_head.kind == K_WRITE);
    v_rd     = (state == B_T_RA) || (state == B_T_RB) || (state == B_T_RC);
    s_rd     = (state == B_ACC_RD) || (state == B_R_RD);
    s_wr     = (state == B_CLR) || (state == B_ACC_WR);
    u_start  = state == B_U_GO;
    out_load = (state == B_OUT) && out_free;
    case (state)
      B_T_RA:  v_raddr = AW'(cmd.a);
      B_T_RB:  v_raddr = AW'(cmd.b);
      default: v_raddr = AW'(cmd.c);
    endcase
    s_raddr = (state == B_R_RD) ? AW'(cmd.vidx) : corner_addr;
    s_waddr = (state == B_CLR) ? clr_cnt : corner_addr;
    s_wdata = (state == B_CLR) ? '0 :
              {SUM_BITS'(ts[2]), SUM_BITS'(ts[1]), SUM_BITS'(ts[0])};
  end

  always_ff @(posedge clk) begin
    if (v_wr)
      vmem[AW'(q_head.vidx)] <= {COORD_BITS'(q_head.z), COORD_BITS'(q_head.y),
                                 COORD_BITS'(q_head.x)};
    if (v_rd) vq <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_wr) smem[s_waddr] <= s_wdata;
    if (s_rd) sq <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_CLR;
      clr_cnt       <= '0;
      init_done     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLR) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(MAX_VERTICES - 1)) begin
          clr_cnt   <= '0;
          init_done <= 1'b1;
        end
      end
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_head;
    case (state)
      B_T_RB: for (int i = 0; i < 3; i++) pa[i] <= signed'(vq[i*COORD_BITS +: COORD_BITS]);
      B_T_RC: for (int i = 0; i < 3; i++) pb[i] <= signed'(vq[i*COORD_BITS +: COORD_BITS]);
      B_T_RD: begin
        for (int i = 0; i < 3; i++) begin
          ab[i] <= ed[i];
          ac[i] <= ed[i + 3];
          cr[i] <= '0;
        end
        k <= 3'd0;
      end
      B_CROSS: begin
        k     <= k + 3'd1;
        prod  <= opa * opb;
        p_dst <= 2'(k >> 1);
        p_sub <= k[0];
        if (k != 3'd0) begin
          if (p_sub) cr[p_dst] <= cr[p_dst] - prod;
          else cr[p_dst] <= cr[p_dst] + prod;
        end
      end
      B_U_WAIT: corner <= 2'd0;
      B_ACC_WR: corner <= corner + 2'd1;
      default: ;
    endcase
    if (out_load) begin
      if (cmd.kind == K_READ_BAD) begin
        m_axis_tdata <= {6'd0, cmd.vidx, 48'd0};
        m_axis_tuser <= 1'b1;
      end else begin
        m_axis_tdata <= {6'd0, cmd.vidx, OUT_W'(signed'(u_nrm[2])),
                         OUT_W'(signed'(u_nrm[1])), OUT_W'(signed'(u_nrm[0]))};
        m_axis_tuser <= u_zero;
      end
    end
  end

  mvna_unit #(
    .NORMAL_BITS(NORMAL_BITS)
  ) u_unit (
    .clk  (clk),
    .rst  (rst),
    .start(u_start),
    .vec  (u_vec),
    .done (u_done),
    .zero (u_zero),
    .nrm  (u_nrm)
  );

endmodule

`default_nettype wire

// ----- rtl/mesh_vertex_normal_accumulator.sv -----
// Vertex normal accumulator top level. Triangles and reads pass through the
// 31-step square root and the NORMAL_BITS+1 step dividers in mvna_unit; a clear
// writes zero to all MAX_VERTICES entries of the sum memory.
// Reset: synchronous; a clearing pass then runs over all MAX_VERTICES entries of
// the sum memory with s_axis_tready low. Positions are undefined until written.
`default_nettype none

module mesh_vertex_normal_accumulator
  import mvna_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16,
  parameter int NORMAL_BITS  = 16,
  parameter int SUM_BITS     = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // vertex_index, coord_x, coord_y, coord_z, tri_a, tri_b, tri_c
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // normal_x, normal_y, normal_z, read_index, zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // zero_normal
  output logic [0:0]                 m_axis_tuser
);

  cmd_t f_cmd, q_head;
  logic f_push, q_full, q_empty, q_pop, init_done;

  mvna_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_full       (q_full),
    .init_done    (init_done),
    .push         (f_push),
    .cmd          (f_cmd)
  );

  mvna_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .din  (f_cmd),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_head),
    .empty(q_empty)
  );

  mvna_back #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS),
    .NORMAL_BITS (NORMAL_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .init_done    (init_done),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking bench: random and directed requests, with an internal integer predictor
// of the normal sums. Depends on rtl/mvna_pkg.sv and mesh_vertex_normal_accumulator.
`timescale 1ns / 1ps

module testbench
  import mvna_pkg::*;
();

  localparam int NVERT = 1024;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  vidx;
    logic [15:0] x, y, z;
    logic [9:0]  a, b, c;
  } req_t;

  typedef struct packed {
    logic [15:0] nx, ny, nz;
    logic [9:0]  ridx;
    logic        zflag;
  } normal_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  always #2ns clk = ~clk;

  mesh_vertex_normal_accumulator dut (.*);

  req_t    pending_reqs[$];
  normal_t expected_normals[$];
  int      error_count = 0;
  int      stall_free = 0;
  bit      stim_done = 0;

  longint  pos[NVERT][3];
  bit      pos_written[NVERT];
  int      written_list[$];
  longint  nsum[NVERT][3];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic longint absval(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint int_sqrt(input longint xin);
    longint unsigned x, r, bit_v;
    x = xin; r = 0; bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= r + bit_v) begin
        x -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else r >>= 1;
      bit_v >>= 2;
    end
    return r;
  endfunction

  // Scale to a Q1.15 unit vector; returns 0 for the zero vector.
  function automatic bit unit_vector(input longint v[3], output longint u[3]);
    longint m[3], mx, s, r, q;
    mx = 0; s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = absval(v[i]); u[i] = 0;
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 0;
    while (mx >= (64'sd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'sd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    r = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 15) + (r >> 1)) / r;
      if (q > 32767) q = 32767;
      u[i] = v[i] < 0 ? -q : q;
    end
    return 1;
  endfunction

  function automatic longint sat_sum(input longint s, input longint n);
    longint t;
    t = s + n;
    if (t > 64'sd8388607) t = 64'sd8388607;
    if (t < -64'sd8388608) t = -64'sd8388608;
    return t;
  endfunction

  task automatic predict_request(input req_t r);
    longint ab[3], ac[3], cr[3], n[3], v[3];
    int idx[3];
    normal_t e;
    case (op_t'(r.op))
      OP_WRITE: begin
        pos[r.vidx][0] = longint'($signed(r.x));
        pos[r.vidx][1] = longint'($signed(r.y));
        pos[r.vidx][2] = longint'($signed(r.z));
      end
      OP_TRI: begin
        idx[0] = int'(r.a); idx[1] = int'(r.b); idx[2] = int'(r.c);
        for (int i = 0; i < 3; i++) begin
          ab[i] = pos[r.b][i] - pos[r.a][i];
          ac[i] = pos[r.c][i] - pos[r.a][i];
        end
        cr[0] = ab[1] * ac[2] - ab[2] * ac[1];
        cr[1] = ab[2] * ac[0] - ab[0] * ac[2];
        cr[2] = ab[0] * ac[1] - ab[1] * ac[0];
        if (unit_vector(cr, n))
          for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++) nsum[idx[k]][i] = sat_sum(nsum[idx[k]][i], n[i]);
      end
      OP_READ: begin
        for (int i = 0; i < 3; i++) v[i] = nsum[r.vidx][i];
        e.zflag = !unit_vector(v, n);
        e.nx = n[0][15:0]; e.ny = n[1][15:0]; e.nz = n[2][15:0];
        e.ridx = r.vidx;
        expected_normals.push_back(e);
      end
      default: foreach (nsum[i]) nsum[i] = '{0, 0, 0};
    endcase
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) s_axis_tvalid <= 0;
    else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_reqs.size() > 0 && (stall_free > 0 || $urandom_range(99) >= 13)) begin
        req_t r;
        r = pending_reqs.pop_front();
        predict_request(r);
        s_axis_tvalid <= 1;
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {r.c, r.b, r.a, r.z, r.y, r.x, r.vidx};
      end else s_axis_tvalid <= 0;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else begin
      if (m_axis_tvalid && m_axis_tready) begin
        normal_t g, e;
        g = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
             m_axis_tdata[57:48], m_axis_tuser[0]};
        if (expected_normals.size() == 0) report_mismatch("unexpected normal result");
        else begin
          e = expected_normals.pop_front();
          if (g.nx !== e.nx) report_mismatch($sformatf("normal_x %h exp %h", g.nx, e.nx));
          if (g.ny !== e.ny) report_mismatch($sformatf("normal_y %h exp %h", g.ny, e.ny));
          if (g.nz !== e.nz) report_mismatch($sformatf("normal_z %h exp %h", g.nz, e.nz));
          if (g.ridx !== e.ridx) report_mismatch($sformatf("read_index %0d exp %0d", g.ridx, e.ridx));
          if (g.zflag !== e.zflag) report_mismatch($sformatf("zero_normal %b exp %b", g.zflag, e.zflag));
        end
      end
      m_axis_tready <= (stall_free > 0) || ($urandom_range(99) >= 13);
    end
  end

  // Watchdog and idle-free stretch control
  int idle_cycles = 0;
  int cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    stall_free <= (cyc % 20000 > 14000) ? 1 : 0;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic req_t mk(input op_t op, input int vidx = 0, input int x = 0,
                              input int y = 0, input int z = 0, input int a = 0,
                              input int b = 0, input int c = 0);
    req_t r;
    r.op = op; r.vidx = 10'(vidx); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
    r.a = 10'(a); r.b = 10'(b); r.c = 10'(c);
    return r;
  endfunction

  function automatic int any_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  task automatic add_write(input int v, input int x, input int y, input int z);
    pending_reqs.push_back(mk(OP_WRITE, v, x, y, z));
    if (!pos_written[v]) begin
      pos_written[v] = 1;
      written_list.push_back(v);
    end
  endtask

  function automatic int rcoord();
    case ($urandom_range(3))
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(1) ? 32767 : -32768;
      default: return $urandom_range(2047) - 1024;
    endcase
  endfunction

  initial begin
    int v, a, b, c;
    foreach (nsum[i]) nsum[i] = '{0, 0, 0};
    // directed: extremes, degenerate, zero reads, clear
    add_write(0, 0, 0, 0);
    add_write(1, 256, 0, 0);
    add_write(2, 0, 256, 0);
    add_write(1023, -32768, -32768, -32768);
    add_write(1022, 32767, 32767, 32767);
    add_write(1021, 32767, -32768, 0);
    pending_reqs.push_back(mk(OP_READ, 5));
    pending_reqs.push_back(mk(OP_TRI, 0, 0, 0, 0, 0, 1, 2));
    pending_reqs.push_back(mk(OP_READ, 0));
    pending_reqs.push_back(mk(OP_TRI, 0, 0, 0, 0, 0, 0, 1));        // degenerate
    pending_reqs.push_back(mk(OP_TRI, 0, 0, 0, 0, 1023, 1022, 1021));
    pending_reqs.push_back(mk(OP_TRI, 0, 0, 0, 0, 1023, 1022, 0));  // collinear
    pending_reqs.push_back(mk(OP_READ, 1023));
    pending_reqs.push_back(mk(OP_READ, 1021));
    for (int i = 0; i < 3; i++) pending_reqs.push_back(mk(OP_TRI, 0, 0, 0, 0, 2, 1, 0));
    pending_reqs.push_back(mk(OP_READ, 2));
    pending_reqs.push_back(mk(OP_CLEAR, 0, 16'hffff, 16'hffff, 16'hffff, 1023, 1023, 1023));
    pending_reqs.push_back(mk(OP_READ, 2));
    pending_reqs.push_back(mk(OP_READ, 1023));
    // random: mostly triangles over a small written pool, with reads
    for (int i = 0; i < 16; i++) add_write(i + 8, rcoord(), rcoord(), rcoord());
    for (int i = 0; i < 450; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3: begin
          v = $urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(8, 40);
          add_write(v, rcoord(), rcoord(), rcoord());
        end
        4, 5, 6, 7, 8: pending_reqs.push_back(mk(OP_READ,
            $urandom_range(1) ? any_written() : $urandom_range(1023)));
        9: if ($urandom_range(5) == 0) pending_reqs.push_back(mk(OP_CLEAR,
            $urandom_range(1023), $urandom_range(65535), 0, 0, $urandom_range(1023)));
        default: begin
          a = any_written(); b = any_written(); c = any_written();
          pending_reqs.push_back(mk(OP_TRI, $urandom_range(1023), $urandom_range(65535),
                                    $urandom_range(65535), $urandom_range(65535), a, b, c));
        end
      endcase
    end
    repeat (5) @(posedge clk);
    rst <= 0;
    wait (pending_reqs.size() == 0);
    @(posedge clk iff (s_axis_tvalid && s_axis_tready) || !s_axis_tvalid);
    wait (expected_normals.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
